// ===== sv/bbc_pkg.sv =====
`default_nettype none
package bbc_pkg;

   // Bracket characters
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_OPEN_ANGLE   = 8'h3C;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_ANGLE  = 8'h3E;

   // Width of the reported nesting depth
   localparam int unsigned NEST_W = 9;

   // Stacked bracket kind
   typedef enum logic [1:0] {
      KIND_CURLY  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_ROUND  = 2'd2,
      KIND_ANGLE  = 2'd3
   } kind_type;

   // Sticky error held across the text
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_MISMATCH = 2'd1,
      ERR_NO_OPEN  = 2'd2,
      ERR_OVERFLOW = 2'd3
   } err_type;

   // Verdict carried with each response
   typedef enum logic [2:0] {
      VERDICT_FINE     = 3'd0,
      VERDICT_MISMATCH = 3'd1,
      VERDICT_NO_OPEN  = 3'd2,
      VERDICT_OVERFLOW = 3'd3,
      VERDICT_BALANCED = 3'd4,
      VERDICT_UNCLOSED = 3'd5
   } verdict_type;

   // Classified byte: hit flag and kind
   typedef struct packed {
      logic     hit;
      kind_type kind;
   } class_type;

   // One response
   typedef struct packed {
      verdict_type        verdict;
      logic [7:0]         open_bracket;
      logic [NEST_W-1:0]  nesting_depth;
   } rsp_type;

   function automatic class_type classify_open(input logic [7:0] b);
      class_type c;
      c.hit  = 1'b1;
      c.kind = KIND_CURLY;
      case (b)
         CHAR_OPEN_CURLY:  c.kind = KIND_CURLY;
         CHAR_OPEN_SQUARE: c.kind = KIND_SQUARE;
         CHAR_OPEN_ROUND:  c.kind = KIND_ROUND;
         CHAR_OPEN_ANGLE:  c.kind = KIND_ANGLE;
         default:          c.hit  = 1'b0;
      endcase
      return c;
   endfunction

   function automatic class_type classify_close(input logic [7:0] b);
      class_type c;
      c.hit  = 1'b1;
      c.kind = KIND_CURLY;
      case (b)
         CHAR_CLOSE_CURLY:  c.kind = KIND_CURLY;
         CHAR_CLOSE_SQUARE: c.kind = KIND_SQUARE;
         CHAR_CLOSE_ROUND:  c.kind = KIND_ROUND;
         CHAR_CLOSE_ANGLE:  c.kind = KIND_ANGLE;
         default:           c.hit  = 1'b0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] open_char(input kind_type k);
      logic [7:0] ch;
      case (k)
         KIND_CURLY:  ch = CHAR_OPEN_CURLY;
         KIND_SQUARE: ch = CHAR_OPEN_SQUARE;
         KIND_ROUND:  ch = CHAR_OPEN_ROUND;
         KIND_ANGLE:  ch = CHAR_OPEN_ANGLE;
         default:     ch = CHAR_OPEN_CURLY;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== sv/bbc_stack_mem.sv =====
`default_nettype none
module bbc_stack_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire bbc_pkg::kind_type wr_data,
   input  wire logic [AW-1:0]   rd_addr,
   output bbc_pkg::kind_type    rd_data
);

   bbc_pkg::kind_type mem_ff [DEPTH];
   bbc_pkg::kind_type rd_ff;

   // Write one entry on push
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data registered
   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ===== sv/bbc_rsp_stage.sv =====
`default_nettype none
module bbc_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire bbc_pkg::rsp_type load_data,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bbc_pkg::rsp_type      rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   bbc_pkg::rsp_type data_ff;

   // Hold the response until taken, refill in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign busy      = valid_ff & rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

`ifndef SYNTHESIS
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy)
      else $error("response loaded while the held one is stalled");
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && data_ff == $past(data_ff)))
      else $error("stalled response changed");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded response not presented");
`endif

endmodule
`default_nettype wire

// ===== sv/bracket_balance_checker_unit.sv =====
// Channel   | ports                                          | role
// ----------+------------------------------------------------+---------------------------
// request   | req_valid, req_stall, req_text_byte,           | one text byte per request
//           | req_end_of_text                                |
// response  | rsp_valid, rsp_stall, rsp_verdict,             | one verdict per byte
//           | rsp_open_bracket, rsp_nesting_depth            |
//
// One request per cycle while the response side does not stall; its response appears in the cycle after acceptance.
// The stack top lives in a register, the entry below it is read from the
// single-port-read stack memory every cycle, so a pop needs no wait.
// Synchronous reset clears depth, error and response valid; no clearing pass.
// A stalled response holds and stalls the request side in the same cycle.
`default_nettype none
module bracket_balance_checker_unit #(
   parameter int unsigned STACK_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_verdict,
   output logic [7:0]      rsp_open_bracket,
   output logic [8:0]      rsp_nesting_depth
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

   logic [DW-1:0]        depth_ff, depth_in, depth_upd;
   bbc_pkg::kind_type    top_ff, top_in;
   bbc_pkg::err_type     err_ff, err_in, err_upd;
   logic [7:0]           ebr_ff, ebr_in, ebr_upd;

   logic                 accept;
   logic                 busy;
   bbc_pkg::class_type   opn, cls;
   logic                 full;
   logic                 wr_en;
   bbc_pkg::kind_type    under_kind;
   logic [DW-1:0]        under_idx;
   logic [DW+bbc_pkg::NEST_W-1:0] nest_ext;
   bbc_pkg::rsp_type     rsp_new, rsp_data;

   assign accept    = req_valid & ~busy;
   assign req_stall = busy;
   assign opn       = bbc_pkg::classify_open(req_text_byte);
   assign cls       = bbc_pkg::classify_close(req_text_byte);
   assign full      = (depth_ff == DW'(STACK_DEPTH));

   // Advance the stack for an accepted byte
   always_comb begin
      depth_upd = depth_ff;
      top_in    = top_ff;
      err_upd   = err_ff;
      ebr_upd   = ebr_ff;
      wr_en     = 1'b0;
      if (accept && err_ff == bbc_pkg::ERR_NONE) begin
         if (opn.hit) begin
            if (full) begin
               err_upd = bbc_pkg::ERR_OVERFLOW;
            end else begin
               wr_en     = 1'b1;
               depth_upd = depth_ff + DW'(1);
               top_in    = opn.kind;
            end
         end else if (cls.hit) begin
            if (depth_ff == '0) begin
               err_upd = bbc_pkg::ERR_NO_OPEN;
            end else if (top_ff == cls.kind) begin
               depth_upd = depth_ff - DW'(1);
               top_in    = under_kind;
            end else begin
               err_upd = bbc_pkg::ERR_MISMATCH;
               ebr_upd = bbc_pkg::open_char(top_ff);
            end
         end
      end
   end

   // Drop all text state after the last byte
   always_comb begin
      depth_in = depth_upd;
      err_in   = err_upd;
      ebr_in   = ebr_upd;
      if (accept && req_end_of_text) begin
         depth_in = '0;
         err_in   = bbc_pkg::ERR_NONE;
         ebr_in   = '0;
      end
   end

   // Form the response from the updated state
   assign nest_ext = {{bbc_pkg::NEST_W{1'b0}}, depth_upd};

   always_comb begin
      rsp_new.verdict       = bbc_pkg::verdict_type'({1'b0, err_upd});
      rsp_new.open_bracket  = (err_upd == bbc_pkg::ERR_MISMATCH) ? ebr_upd : 8'h00;
      rsp_new.nesting_depth = nest_ext[bbc_pkg::NEST_W-1:0];
      if (req_end_of_text && err_upd == bbc_pkg::ERR_NONE) begin
         if (depth_upd == '0) begin
            rsp_new.verdict = bbc_pkg::VERDICT_BALANCED;
         end else begin
            rsp_new.verdict      = bbc_pkg::VERDICT_UNCLOSED;
            rsp_new.open_bracket = bbc_pkg::open_char(top_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= bbc_pkg::ERR_NONE;
         ebr_ff   <= '0;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
         ebr_ff   <= ebr_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Prefetch the entry just below the next top
   assign under_idx = depth_in - DW'(2);

   bbc_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (opn.kind),
      .rd_addr (under_idx[AW-1:0]),
      .rd_data (under_kind)
   );

   bbc_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (rsp_new),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_verdict       = rsp_data.verdict;
   assign rsp_open_bracket  = rsp_data.open_bracket;
   assign rsp_nesting_depth = rsp_data.nesting_depth;

`ifndef SYNTHESIS
   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_end_of_text && err_ff != bbc_pkg::ERR_NONE)
      |=> (err_ff == $past(err_ff) && depth_ff == $past(depth_ff)))
      else $error("error or depth changed after an error");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text)
      |=> (depth_ff == '0 && err_ff == bbc_pkg::ERR_NONE))
      else $error("state not cleared after last byte");
   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (err_ff == bbc_pkg::ERR_NONE && !full))
      else $error("stack written while in error or full");
`endif

endmodule
`default_nettype wire

// ===== bench/bracket_check_tb_pkg.sv =====
package bracket_check_tb_pkg;

   // Opening character of a stacked kind
   function automatic logic [7:0] opening_byte(input bbc_pkg::kind_type k);
      logic [7:0] ch;
      case (k)
         bbc_pkg::KIND_SQUARE: ch = bbc_pkg::CHAR_OPEN_SQUARE;
         bbc_pkg::KIND_ROUND:  ch = bbc_pkg::CHAR_OPEN_ROUND;
         bbc_pkg::KIND_ANGLE:  ch = bbc_pkg::CHAR_OPEN_ANGLE;
         default:              ch = bbc_pkg::CHAR_OPEN_CURLY;
      endcase
      return ch;
   endfunction

   // Closing character of a stacked kind
   function automatic logic [7:0] closing_byte(input bbc_pkg::kind_type k);
      logic [7:0] ch;
      case (k)
         bbc_pkg::KIND_SQUARE: ch = bbc_pkg::CHAR_CLOSE_SQUARE;
         bbc_pkg::KIND_ROUND:  ch = bbc_pkg::CHAR_CLOSE_ROUND;
         bbc_pkg::KIND_ANGLE:  ch = bbc_pkg::CHAR_CLOSE_ANGLE;
         default:              ch = bbc_pkg::CHAR_CLOSE_CURLY;
      endcase
      return ch;
   endfunction

   // Tell brackets from plain text; give back kind and direction
   function automatic bit decode_bracket(input logic [7:0] b,
                                         output bbc_pkg::kind_type k,
                                         output bit opening);
      decode_bracket = 1'b1;
      opening = 1'b0;
      k = bbc_pkg::KIND_CURLY;
      case (b)
         bbc_pkg::CHAR_OPEN_CURLY: begin
            k = bbc_pkg::KIND_CURLY;
            opening = 1'b1;
         end
         bbc_pkg::CHAR_OPEN_SQUARE: begin
            k = bbc_pkg::KIND_SQUARE;
            opening = 1'b1;
         end
         bbc_pkg::CHAR_OPEN_ROUND: begin
            k = bbc_pkg::KIND_ROUND;
            opening = 1'b1;
         end
         bbc_pkg::CHAR_OPEN_ANGLE: begin
            k = bbc_pkg::KIND_ANGLE;
            opening = 1'b1;
         end
         bbc_pkg::CHAR_CLOSE_CURLY:  k = bbc_pkg::KIND_CURLY;
         bbc_pkg::CHAR_CLOSE_SQUARE: k = bbc_pkg::KIND_SQUARE;
         bbc_pkg::CHAR_CLOSE_ROUND:  k = bbc_pkg::KIND_ROUND;
         bbc_pkg::CHAR_CLOSE_ANGLE:  k = bbc_pkg::KIND_ANGLE;
         default:                    decode_bracket = 1'b0;
      endcase
   endfunction

   class balance_scoreboard;
      bbc_pkg::kind_type stack_mem[];
      int unsigned       capacity;
      int unsigned       depth;
      bbc_pkg::err_type  err;
      logic [7:0]        err_bracket;
      bbc_pkg::rsp_type  pending_verdicts[$];
      int unsigned       fail_count;
      int unsigned       byte_count;
      int unsigned       text_count;
      int unsigned       verdict_tally[6];

      function new(int unsigned size);
         capacity = size;
         stack_mem = new[size];
         depth = 0;
         err = bbc_pkg::ERR_NONE;
         err_bracket = 8'h00;
         fail_count = 0;
         byte_count = 0;
         text_count = 0;
         foreach (verdict_tally[i]) verdict_tally[i] = 0;
      endfunction

      // Advance the stack for one accepted request and queue its verdict
      function void note_byte(logic [7:0] b, logic last);
         bbc_pkg::kind_type k;
         bit                opening;
         bit                hit;
         bbc_pkg::rsp_type  exp;
         hit = decode_bracket(b, k, opening);
         if (err == bbc_pkg::ERR_NONE && hit) begin
            if (opening) begin
               if (depth >= capacity) begin
                  err = bbc_pkg::ERR_OVERFLOW;
               end else begin
                  stack_mem[depth] = k;
                  depth++;
               end
            end else if (depth == 0) begin
               err = bbc_pkg::ERR_NO_OPEN;
            end else if (stack_mem[depth-1] == k) begin
               depth--;
            end else begin
               err = bbc_pkg::ERR_MISMATCH;
               err_bracket = opening_byte(stack_mem[depth-1]);
            end
         end

         exp.verdict = bbc_pkg::verdict_type'({1'b0, err});
         exp.open_bracket = (err == bbc_pkg::ERR_MISMATCH) ? err_bracket : 8'h00;
         if (last && err == bbc_pkg::ERR_NONE) begin
            if (depth == 0) begin
               exp.verdict = bbc_pkg::VERDICT_BALANCED;
            end else begin
               exp.verdict = bbc_pkg::VERDICT_UNCLOSED;
               exp.open_bracket = opening_byte(stack_mem[depth-1]);
            end
         end
         exp.nesting_depth = bbc_pkg::NEST_W'(depth);
         pending_verdicts.push_back(exp);
         byte_count++;

         // Clear for the next text
         if (last) begin
            depth = 0;
            err = bbc_pkg::ERR_NONE;
            err_bracket = 8'h00;
            text_count++;
         end
      endfunction

      // Compare one accepted response with the oldest queued verdict
      function void check_verdict(logic [2:0] v, logic [7:0] ob, logic [8:0] nd);
         bbc_pkg::rsp_type exp;
         if (pending_verdicts.size() == 0) begin
            flag($sformatf("unexpected response: verdict %0d bracket %h depth %0d",
                           v, ob, nd));
            return;
         end
         exp = pending_verdicts.pop_front();
         verdict_tally[int'(exp.verdict)]++;
         if (v !== exp.verdict || ob !== exp.open_bracket || nd !== exp.nesting_depth)
            flag($sformatf({"response %0d: expected verdict %0d bracket %h depth %0d,",
                            " got %0d %h %0d"},
                           byte_count - pending_verdicts.size(), exp.verdict,
                           exp.open_bracket, exp.nesting_depth, v, ob, nd));
      endfunction

      // Report verdicts that never showed up
      function void close_out();
         if (pending_verdicts.size() != 0)
            flag($sformatf("%0d responses still outstanding", pending_verdicts.size()));
      endfunction

      // Count a failure; show only the first few
      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10) $display("MISMATCH: %s", msg);
      endfunction
   endclass

endpackage

// ===== bench/tb_bracket_balance_checker_unit.sv =====
module tb_bracket_balance_checker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STACK_SIZE     = 256;
   localparam int unsigned RANDOM_TARGET  = 650;
   localparam int unsigned MAX_GAP        = 14;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned CYCLE_LIMIT    = 300000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_verdict;
   logic [7:0] rsp_open_bracket;
   logic [8:0] rsp_nesting_depth;

   bracket_check_tb_pkg::balance_scoreboard sb;
   logic [7:0]        text_buf[$];
   int unsigned       cycle_count = 0;
   bit                sender_burst = 1'b0;
   bit                receiver_burst = 1'b0;
   bit                hold_pending = 1'b0;

   always #5 clock = ~clock;

   bracket_balance_checker_unit #(
      .STACK_DEPTH (STACK_SIZE)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_open_bracket  (rsp_open_bracket),
      .rsp_nesting_depth (rsp_nesting_depth)
   );

   // Drop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_text_byte, req_end_of_text);
         if (rsp_valid && !rsp_stall)
            sb.check_verdict(rsp_verdict, rsp_open_bracket, rsp_nesting_depth);
      end
   end

   // Receiver: stall a random number of cycles before each response, or a long hold when one is pending
   initial begin : response_sink
      int unsigned gap;
      @(negedge clock);
      forever begin
         gap = receiver_burst ? 0 : $urandom_range(MAX_GAP, 0);
         if (hold_pending) begin
            hold_pending = 1'b0;
            gap = HOLD_CYCLES;
         end
         repeat (gap) begin
            rsp_stall = 1'b1;
            @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Offer one request after a random gap; hold it until accepted
   task automatic send_request(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(MAX_GAP, 0);
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_byte = b;
      req_end_of_text = last;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_request(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_literal(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      send_text();
   endtask

   // Any byte that is not a bracket
   function automatic logic [7:0] filler_byte();
      logic [7:0]        b;
      bbc_pkg::kind_type k;
      bit                o;
      do b = 8'($urandom_range(255, 0));
      while (bracket_check_tb_pkg::decode_bracket(b, k, o));
      return b;
   endfunction

   // Random nesting with plain text between brackets
   function automatic void build_nested_text(int unsigned max_len, int unsigned max_nest,
                                             bit close_all);
      bbc_pkg::kind_type open_kinds[$];
      bbc_pkg::kind_type k;
      int unsigned       len;
      int unsigned       roll;
      text_buf.delete();
      len = $urandom_range(max_len, 1);
      for (int unsigned i = 0; i < len; i++) begin
         roll = $urandom_range(99, 0);
         if (roll < 40 && open_kinds.size() < max_nest) begin
            k = bbc_pkg::kind_type'(2'($urandom_range(3, 0)));
            open_kinds.push_back(k);
            text_buf.push_back(bracket_check_tb_pkg::opening_byte(k));
         end else if (roll < 75 && open_kinds.size() > 0) begin
            text_buf.push_back(bracket_check_tb_pkg::closing_byte(open_kinds.pop_back()));
         end else begin
            text_buf.push_back(filler_byte());
         end
      end
      while (close_all && open_kinds.size() > 0)
         text_buf.push_back(bracket_check_tb_pkg::closing_byte(open_kinds.pop_back()));
   endfunction

   // Overwrite a byte or two with stray brackets
   function automatic void break_text();
      int unsigned       n;
      int unsigned       pos;
      bbc_pkg::kind_type k;
      n = $urandom_range(2, 1);
      repeat (n) begin
         pos = $urandom_range(text_buf.size() - 1, 0);
         k = bbc_pkg::kind_type'(2'($urandom_range(3, 0)));
         text_buf[pos] = $urandom_range(1, 0) ? bracket_check_tb_pkg::opening_byte(k)
                                              : bracket_check_tb_pkg::closing_byte(k);
      end
   endfunction

   function automatic void build_noise_text(int unsigned max_len);
      int unsigned len;
      text_buf.delete();
      len = $urandom_range(max_len, 1);
      repeat (len) text_buf.push_back(8'($urandom_range(255, 0)));
   endfunction

   // Fill the stack, pop from full, refill and overflow
   function automatic void build_deep_text();
      bbc_pkg::kind_type open_kinds[$];
      bbc_pkg::kind_type k;
      text_buf.delete();
      repeat (STACK_SIZE) begin
         k = bbc_pkg::kind_type'(2'($urandom_range(3, 0)));
         open_kinds.push_back(k);
         text_buf.push_back(bracket_check_tb_pkg::opening_byte(k));
      end
      repeat (3)
         text_buf.push_back(bracket_check_tb_pkg::closing_byte(open_kinds.pop_back()));
      repeat (4)
         text_buf.push_back(bracket_check_tb_pkg::opening_byte(
            bbc_pkg::kind_type'(2'($urandom_range(3, 0)))));
      repeat (3) text_buf.push_back(filler_byte());
   endfunction

   initial begin : stimulus
      int unsigned roll;
      int unsigned random_bytes;
      int unsigned text_no;
      bit          deep_done;
      random_bytes = 0;
      text_no = 0;
      deep_done = 1'b0;
      sb = new(STACK_SIZE);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed texts: every pair, plain bytes at both ends of the range,
      // close on empty, mismatch then ignored bytes, unclosed end
      send_literal("{[(<>)]}");
      text_buf = '{8'h00};
      send_text();
      text_buf = '{8'hFF};
      send_text();
      send_literal(")");
      send_literal("(]x");
      send_literal("[<");
      send_literal("})");
      send_literal("<{}");

      // Random texts, mostly well formed
      while (random_bytes < RANDOM_TARGET) begin
         text_no++;
         sender_burst = ($urandom_range(3, 0) == 0);
         receiver_burst = ($urandom_range(3, 0) == 0);
         if (text_no == 6 || text_no == 40) begin
            // Long receiver hold while requests keep coming
            hold_pending = 1'b1;
            sender_burst = 1'b1;
            build_nested_text(40, 10, 1'b1);
         end else if (!deep_done && random_bytes > 200) begin
            deep_done = 1'b1;
            build_deep_text();
         end else begin
            roll = $urandom_range(99, 0);
            if (roll < 60) begin
               build_nested_text(24, 12, 1'b1);
            end else if (roll < 72) begin
               build_nested_text(16, 8, 1'b0);
            end else if (roll < 92) begin
               build_nested_text(20, 8, $urandom_range(1, 0));
               break_text();
            end else begin
               build_noise_text(10);
            end
         end
         random_bytes += text_buf.size();
         send_text();
      end
      req_valid = 1'b0;

      // Drain, then allow a few more cycles for stray responses
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.close_out();

      $display("Run covered %0d requests over %0d texts, one filling the %0d-entry stack,",
               sb.byte_count, sb.text_count, STACK_SIZE);
      $display({"with verdicts fine %0d, mismatch %0d, no-open %0d, overflow %0d,",
                " balanced %0d, unclosed %0d"},
               sb.verdict_tally[0], sb.verdict_tally[1], sb.verdict_tally[2],
               sb.verdict_tally[3], sb.verdict_tally[4], sb.verdict_tally[5]);
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/bbc_pkg.sv
sv/bbc_stack_mem.sv
sv/bbc_rsp_stage.sv
sv/bracket_balance_checker_unit.sv
bench/bracket_check_tb_pkg.sv
bench/tb_bracket_balance_checker_unit.sv
